[rtl/vle_pkg.sv]
package vle_pkg;

    localparam int VALUE_W   = 64;
    localparam int ROOM_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int MAG_BYTES = VALUE_W / BYTE_W;
    localparam int MAX_ITEMS = MAG_BYTES + 1;
    localparam int SHIFT_W   = MAX_ITEMS * BYTE_W;
    localparam int NB_W      = $clog2(MAG_BYTES + 1);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // single-byte range is -112 .. 127; for negatives the inverted value is 0 .. 111
    localparam logic [VALUE_W-1:0] SMALL_POS_MAX = VALUE_W'(127);
    localparam logic [VALUE_W-1:0] SMALL_NEG_MAX = VALUE_W'(111);

    // prefix = -120 - n (negative) or -112 - n (non-negative), as unsigned bytes
    localparam logic [BYTE_W-1:0] PREFIX_NEG_BASE = BYTE_W'(136);
    localparam logic [BYTE_W-1:0] PREFIX_POS_BASE = BYTE_W'(144);

endpackage

[rtl/vlong_encoder.sv]
// Channel   Direction  Handshake                 Payload
// request   in         start / busy              value[63:0], room[15:0]
// result    out        strobe (no back-pressure) out_byte[7:0], last, no_room
//
// Three register stages (capture, magnitude/byte scan, length/alignment) feed
// a byte shift register that sends one result per cycle.
// A request yields 1 to 9 results, sent at one byte per cycle.
// busy rises when the capture stage is full and cannot move forward.
// rst_n clears all valid bits and the shift count; no result follows reset.
// The result side cannot stall; the stages stall only behind the shift register.
module vlong_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [vle_pkg::VALUE_W-1:0]  value,
    input  logic        [vle_pkg::ROOM_W-1:0]   room,
    output logic                                strobe,
    output logic        [vle_pkg::BYTE_W-1:0]   out_byte,
    output logic                                last,
    output logic                                no_room
);
    import vle_pkg::*;

    // stage 1: capture
    logic                s1_valid_reg, s1_valid_next;
    logic [VALUE_W-1:0]  s1_value_reg;
    logic [ROOM_W-1:0]   s1_room_reg;

    // stage 2: magnitude, byte scan
    logic                  s2_valid_reg, s2_valid_next;
    logic [VALUE_W-1:0]    s2_mag_reg;
    logic                  s2_neg_reg;
    logic                  s2_small_reg;
    logic [MAG_BYTES-1:0]  s2_nz_reg;
    logic [BYTE_W-1:0]     s2_low_reg;
    logic [ROOM_W-1:0]     s2_room_reg;

    // stage 3: aligned bytes, length, room check
    logic                s3_valid_reg, s3_valid_next;
    logic [SHIFT_W-1:0]  s3_bytes_reg;
    logic [CNT_W-1:0]    s3_len_reg;
    logic                s3_no_room_reg;

    // output shift register
    logic [SHIFT_W-1:0]  sh_reg, sh_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                nr_reg, nr_next;

    logic accept, s1_ready, s2_ready, s3_ready, ser_load;
    logic s1_move, s2_move, s3_move;

    // stage 2 logic
    logic                 neg_c;
    logic [VALUE_W-1:0]   mag_c;
    logic                 small_c;
    logic [MAG_BYTES-1:0] nz_c;

    // stage 3 logic
    logic [NB_W-1:0]     nb_c;
    logic [CNT_W-1:0]    len_c;
    logic [BYTE_W-1:0]   prefix_c;
    logic [VALUE_W-1:0]  aligned_c;
    logic [SHIFT_W-1:0]  bytes_c;
    logic                no_room_c;

    assign ser_load = s3_valid_reg && (left_reg <= CNT_W'(1));
    assign s3_ready = !s3_valid_reg || ser_load;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign busy     = !s1_ready;
    assign accept   = start && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign s2_move  = s2_valid_reg && s3_ready;
    assign s3_move  = ser_load;

    assign s1_valid_next = accept || (s1_valid_reg && !s1_move);
    assign s2_valid_next = s1_move || (s2_valid_reg && !s2_move);
    assign s3_valid_next = s2_move || (s3_valid_reg && !s3_move);

    always_comb
    begin
        neg_c   = s1_value_reg[VALUE_W-1];
        mag_c   = neg_c ? ~s1_value_reg : s1_value_reg;
        small_c = neg_c ? (mag_c <= SMALL_NEG_MAX) : (mag_c <= SMALL_POS_MAX);
        for (int i = 0; i < MAG_BYTES; i++)
        begin
            nz_c[i] = |mag_c[i*BYTE_W +: BYTE_W];
        end
    end

    always_comb
    begin
        nb_c = '0;
        for (int i = 0; i < MAG_BYTES; i++)
        begin
            if (s2_nz_reg[i])
            begin
                nb_c = NB_W'(i + 1);
            end
        end
        len_c     = s2_small_reg ? CNT_W'(1) : CNT_W'(nb_c) + CNT_W'(1);
        no_room_c = s2_room_reg < ROOM_W'(len_c);
        prefix_c  = (s2_neg_reg ? PREFIX_NEG_BASE : PREFIX_POS_BASE) - BYTE_W'(nb_c);
        aligned_c = s2_mag_reg << ((MAG_BYTES - 32'(nb_c)) * BYTE_W);
        if (s2_small_reg)
        begin
            bytes_c = {s2_low_reg, {VALUE_W{1'b0}}};
        end
        else
        begin
            bytes_c = {prefix_c, aligned_c};
        end
    end

    always_comb
    begin
        sh_next   = sh_reg;
        left_next = left_reg;
        nr_next   = nr_reg;
        if (ser_load)
        begin
            sh_next   = s3_no_room_reg ? '0 : s3_bytes_reg;
            left_next = s3_no_room_reg ? CNT_W'(1) : s3_len_reg;
            nr_next   = s3_no_room_reg;
        end
        else if (left_reg != '0)
        begin
            sh_next   = sh_reg << BYTE_W;
            left_next = left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            left_reg     <= '0;
            nr_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            left_reg     <= left_next;
            nr_reg       <= nr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= value;
            s1_room_reg  <= room;
        end
        if (s1_move)
        begin
            s2_mag_reg   <= mag_c;
            s2_neg_reg   <= neg_c;
            s2_small_reg <= small_c;
            s2_nz_reg    <= nz_c;
            s2_low_reg   <= s1_value_reg[BYTE_W-1:0];
            s2_room_reg  <= s1_room_reg;
        end
        if (s2_move)
        begin
            s3_bytes_reg   <= bytes_c;
            s3_len_reg     <= len_c;
            s3_no_room_reg <= no_room_c;
        end
        sh_reg <= sh_next;
    end

    assign strobe   = left_reg != '0;
    assign out_byte = sh_reg[SHIFT_W-1 -: BYTE_W];
    assign last     = left_reg == CNT_W'(1);
    assign no_room  = strobe && nr_reg;

    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && !no_room)
        else $error("encoding broken off before last byte");

    a_nr_last: assert property (@(posedge clk) disable iff (!rst_n)
        no_room |-> last && out_byte == '0)
        else $error("room error result not single zero item");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && strobe && !last)
        else $error("busy without a full stalled pipeline");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= CNT_W'(MAX_ITEMS))
        else $error("more than nine results pending");

endmodule

[tb/vle_encode_checker.sv]
`timescale 1ns / 100ps

module vle_encode_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [vle_pkg::VALUE_W-1:0]       value,
    input  logic [vle_pkg::ROOM_W-1:0]        room,
    input  logic                              strobe,
    input  logic [vle_pkg::BYTE_W-1:0]        out_byte,
    input  logic                              last,
    input  logic                              no_room,
    output int                                mismatches,
    output int                                outstanding,
    output int                                requests_seen,
    output int                                bytes_seen,
    output int                                rejects_seen,
    output int                                nine_byte_seen
);
    import vle_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              fin;
        logic              rejected;
    } enc_byte_t;

    enc_byte_t expected_bytes[$];

    function automatic void encode_vlong(input logic [VALUE_W-1:0] v,
                                         input logic [ROOM_W-1:0] r);
        logic              neg;
        logic [VALUE_W-1:0] mag;
        logic              one_byte;
        int                nb;
        int                len;
        int                i;
        enc_byte_t         e;
        neg = v[VALUE_W-1];
        mag = neg ? ~v : v;
        nb = 0;
        for (i = 0; i < MAG_BYTES; i++)
            if (mag[i*BYTE_W +: BYTE_W] != '0)
                nb = i + 1;
        one_byte = neg ? (mag <= SMALL_NEG_MAX) : (mag <= SMALL_POS_MAX);
        len = one_byte ? 1 : nb + 1;
        if (int'(r) < len)
        begin
            e = '{data: '0, fin: 1'b1, rejected: 1'b1};
            expected_bytes.push_back(e);
        end
        else if (one_byte)
        begin
            e = '{data: v[BYTE_W-1:0], fin: 1'b1, rejected: 1'b0};
            expected_bytes.push_back(e);
        end
        else
        begin
            e.data     = (neg ? PREFIX_NEG_BASE : PREFIX_POS_BASE) - BYTE_W'(nb);
            e.fin      = 1'b0;
            e.rejected = 1'b0;
            expected_bytes.push_back(e);
            for (i = nb - 1; i >= 0; i--)
            begin
                e.data = mag[i*BYTE_W +: BYTE_W];
                e.fin  = (i == 0);
                expected_bytes.push_back(e);
            end
            if (nb == MAG_BYTES)
                nine_byte_seen++;
        end
    endfunction

    initial
    begin
        mismatches     = 0;
        outstanding    = 0;
        requests_seen  = 0;
        bytes_seen     = 0;
        rejects_seen   = 0;
        nine_byte_seen = 0;
    end

    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                requests_seen++;
                encode_vlong(value, room);
            end
            if (strobe)
            begin
                bytes_seen++;
                if (no_room)
                    rejects_seen++;
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result byte=%02h last=%0b no_room=%0b",
                                 $realtime, out_byte, last, no_room);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data || last !== want.fin
                        || no_room !== want.rejected)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: byte/last/no_room exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     $realtime, want.data, want.fin, want.rejected,
                                     out_byte, last, no_room);
                    end
                end
            end
            outstanding <= expected_bytes.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import vle_pkg::*;

    localparam int NUM_RANDOM = 158;
    localparam int NUM_DIRECTED = 22;
    localparam int QUIET_LIMIT = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [VALUE_W-1:0]  value = '0;
    logic [ROOM_W-1:0]   room = '0;
    logic                busy;
    logic                strobe;
    logic [BYTE_W-1:0]   out_byte;
    logic                last;
    logic                no_room;

    int mismatches;
    int outstanding;
    int requests_seen;
    int bytes_seen;
    int rejects_seen;
    int nine_byte_seen;
    int quiet_cycles = 0;

    logic [VALUE_W-1:0] dir_value [NUM_DIRECTED] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_007F, 64'h0000_0000_0000_0080,
        64'h0000_0000_0000_0080, 64'hFFFF_FFFF_FFFF_FF90,
        64'hFFFF_FFFF_FFFF_FF8F, 64'hFFFF_FFFF_FFFF_FF8F,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_00FF,
        64'h0000_0000_0000_0100, 64'h0000_0000_0000_0100,
        64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FEFF,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h0000_00FF_FFFF_FFFF, 64'h5555_AAAA_5555_AAAA,
        64'hAAAA_5555_AAAA_5555, 64'h0123_4567_89AB_CDEF
    };
    logic [ROOM_W-1:0] dir_room [NUM_DIRECTED] = '{
        16'd1, 16'd0, 16'd9, 16'd2, 16'd1, 16'd1, 16'd2, 16'd1,
        16'hFFFF, 16'd2, 16'd3, 16'd2, 16'd2, 16'd3, 16'd9, 16'd8,
        16'd9, 16'd0, 16'd6, 16'hFFFF, 16'h8000, 16'd10
    };

    always #5 clk = ~clk;

    vlong_encoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .room     (room),
        .strobe   (strobe),
        .out_byte (out_byte),
        .last     (last),
        .no_room  (no_room)
    );

    vle_encode_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .value          (value),
        .room           (room),
        .strobe         (strobe),
        .out_byte       (out_byte),
        .last           (last),
        .no_room        (no_room),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .requests_seen  (requests_seen),
        .bytes_seen     (bytes_seen),
        .rejects_seen   (rejects_seen),
        .nine_byte_seen (nine_byte_seen)
    );

    // returns at the edge that takes the request
    task automatic send_request(input logic [VALUE_W-1:0] v, input logic [ROOM_W-1:0] r,
                                input bit may_idle);
        if (may_idle)
            while ($urandom_range(0, 99) < 11)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        value <= v;
        room  <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int                 nb;
        logic [VALUE_W-1:0] mag;
        mag = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            return mag;
        nb = $urandom_range(0, MAG_BYTES);
        if (nb < MAG_BYTES)
            mag = mag & ((64'd1 << (nb * BYTE_W)) - 64'd1);
        if ($urandom_range(0, 3) == 0)
            mag = ($urandom_range(0, 1) == 1) ? 64'd127 + $urandom_range(0, 2)
                                              : 64'd110 + $urandom_range(0, 3);
        return $urandom_range(0, 1) ? ~mag : mag;
    endfunction

    function automatic logic [ROOM_W-1:0] random_room();
        case ($urandom_range(0, 3))
            0, 1:    return ROOM_W'($urandom_range(0, 10));
            2:       return ROOM_W'($urandom_range(0, 65535));
            default: return ROOM_W'($urandom_range(9, 65535));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(dir_value[i], dir_room[i], 1'b1);

        // hold off until every byte of the directed requests is out
        drain_results();

        for (int i = 0; i < NUM_RANDOM; i++)
            send_request(random_value(), random_room(), !(i >= 70 && i < 130));

        drain_results();
        repeat (20) @(posedge clk);

        $display("Covered %0d requests (%0d directed), %0d result bytes checked.",
                 requests_seen, NUM_DIRECTED, bytes_seen);
        $display("Room rejections: %0d, full nine-byte encodings: %0d.",
                 rejects_seen, nine_byte_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
